@@ hw/rtl/nec_ir_frame_decoder_core_assert.svh @@
// ----------------------------------------------------------------------------
// NEC IR frame decoder assertion macros
// Shared concurrent assertion forms used by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef NEC_IR_FRAME_DECODER_CORE_ASSERT_SVH
`define NEC_IR_FRAME_DECODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NECIR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("necir assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NECIR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("necir assertion failed");

`endif

@@ hw/rtl/necir_pkg.sv @@
// ----------------------------------------------------------------------------
// NEC IR frame decoder package
// Widths, register indexes and reset values shared by the decoder files.
// ----------------------------------------------------------------------------
package necir_pkg;

   localparam int INTERVAL_W = 16;
   localparam int BYTE_W     = 8;
   localparam int FRAME_W    = 32;
   localparam int POS_W      = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Header slot plus 32 data edges.
   localparam logic [POS_W-1:0] FRAME_EDGES = 6'd33;
   localparam logic [BYTE_W-1:0] INV_MATCH  = 8'hFF;

   localparam logic [INTERVAL_W-1:0] SYNC_MIN_RST = 16'd50;
   localparam logic [INTERVAL_W-1:0] SYNC_MAX_RST = 16'd150;
   localparam logic [BYTE_W-1:0]     ZERO_MIN_RST = 8'd8;
   localparam logic [BYTE_W-1:0]     ZERO_MAX_RST = 8'd15;
   localparam logic [BYTE_W-1:0]     ONE_MIN_RST  = 8'd18;
   localparam logic [BYTE_W-1:0]     ONE_MAX_RST  = 8'd25;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SYNC_MIN = 3'd0,
      CSR_SYNC_MAX = 3'd1,
      CSR_ZERO_MIN = 3'd2,
      CSR_ZERO_MAX = 3'd3,
      CSR_ONE_MIN  = 3'd4,
      CSR_ONE_MAX  = 3'd5
   } csr_index_type;

endpackage

@@ hw/rtl/necir_req_if.sv @@
// ----------------------------------------------------------------------------
// NEC IR edge channel
// Valid/ready channel carrying one falling-edge interval per transfer.
// ----------------------------------------------------------------------------
interface necir_req_if
   import necir_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [INTERVAL_W-1:0] edge_interval;

   modport source (output valid, output edge_interval, input ready);
   modport sink   (input valid, input edge_interval, output ready);
endinterface

@@ hw/rtl/necir_rsp_if.sv @@
// ----------------------------------------------------------------------------
// NEC IR frame channel
// Valid/ready channel carrying one decoded frame per transfer.
// ----------------------------------------------------------------------------
interface necir_rsp_if
   import necir_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  device_address;
   logic [BYTE_W-1:0]  command_code;
   logic [FRAME_W-1:0] raw_frame;
   logic               frame_valid;

   modport source (output valid, output device_address, output command_code,
                   output raw_frame, output frame_valid, input ready);
   modport sink   (input valid, input device_address, input command_code,
                   input raw_frame, input frame_valid, output ready);
endinterface

@@ hw/rtl/nec_ir_frame_decoder_core.sv @@
// ----------------------------------------------------------------------------
// NEC IR frame decoder core
// Decodes falling-edge intervals into address, command and raw frame words.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  req_ch   in         edge_interval, one falling edge per transfer
//  rsp_ch   out        device_address, command_code, raw_frame, frame_valid
//  csr_*    in         window register writes, no read-back
//
// One edge is accepted per cycle while req_ch.ready is high. The last edge of
// a frame passes the edge register, loaded at the transfer, and then the
// result register, which drives rsp_ch.valid. The single decode stage updates
// the frame state as each edge leaves the edge register.
// Synchronous reset disarms capture and restores the default windows.
// A result held by a stalled sink holds the edge register, and req_ch.ready
// falls only when both stages are occupied.
// ----------------------------------------------------------------------------
`include "nec_ir_frame_decoder_core_assert.svh"

module nec_ir_frame_decoder_core
   import necir_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   necir_req_if.sink             req_ch,
   necir_rsp_if.source           rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   logic [INTERVAL_W-1:0] sync_min_ff, sync_max_ff;
   logic [BYTE_W-1:0]     zero_min_ff, zero_max_ff, one_min_ff, one_max_ff;

   logic                  s1_valid_ff, s1_valid_in;
   logic [INTERVAL_W-1:0] s1_interval_ff;

   logic                  armed_ff, armed_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [FRAME_W-1:0]    bits_ff, bits_in;
   logic                  prev_ff, prev_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]    rsp_frame_ff;

   logic                  advance, req_fire, s1_fire, emit;
   logic                  sync_hit, zero_hit, one_hit, bit_val;
   logic [POS_W-1:0]      pos_eff, pos_next;
   logic [4:0]            bit_idx;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_min_ff <= SYNC_MIN_RST;
         sync_max_ff <= SYNC_MAX_RST;
         zero_min_ff <= ZERO_MIN_RST;
         zero_max_ff <= ZERO_MAX_RST;
         one_min_ff  <= ONE_MIN_RST;
         one_max_ff  <= ONE_MAX_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_SYNC_MIN: sync_min_ff <= csr_wr_data;
            CSR_SYNC_MAX: sync_max_ff <= csr_wr_data;
            CSR_ZERO_MIN: zero_min_ff <= csr_wr_data[BYTE_W-1:0];
            CSR_ZERO_MAX: zero_max_ff <= csr_wr_data[BYTE_W-1:0];
            CSR_ONE_MIN:  one_min_ff  <= csr_wr_data[BYTE_W-1:0];
            CSR_ONE_MAX:  one_max_ff  <= csr_wr_data[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake and stage control.
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign s1_fire      = s1_valid_ff && advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // Decode of one edge against the current frame state.
   always_comb begin
      sync_hit = (s1_interval_ff >= sync_min_ff) && (s1_interval_ff < sync_max_ff);
      // Bit windows are compared over the full interval width.
      zero_hit = (s1_interval_ff >= INTERVAL_W'(zero_min_ff)) &&
                 (s1_interval_ff <  INTERVAL_W'(zero_max_ff));
      one_hit  = (s1_interval_ff >= INTERVAL_W'(one_min_ff)) &&
                 (s1_interval_ff <  INTERVAL_W'(one_max_ff));
      pos_eff  = sync_hit ? '0 : pos_ff;
      bit_val  = zero_hit ? 1'b0 : (one_hit ? 1'b1 : prev_ff);
      bit_idx  = 5'(pos_eff - 6'd1);
      pos_next = pos_eff + 6'd1;

      armed_in = armed_ff;
      pos_in   = pos_ff;
      bits_in  = bits_ff;
      prev_in  = prev_ff;
      emit     = 1'b0;

      if (!armed_ff) begin
         armed_in = 1'b1;
         pos_in   = '0;
      end else if (pos_eff == '0 || pos_eff >= FRAME_EDGES) begin
         // Header slot: start a fresh frame.
         pos_in  = 6'd1;
         bits_in = '0;
         prev_in = 1'b0;
      end else begin
         prev_in          = bit_val;
         bits_in[bit_idx] = bits_ff[bit_idx] | bit_val;
         if (pos_next == FRAME_EDGES) begin
            emit     = 1'b1;
            pos_in   = '0;
            armed_in = 1'b0;
         end else begin
            pos_in = pos_next;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = s1_fire && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         armed_ff     <= 1'b0;
         pos_ff       <= '0;
         bits_ff      <= '0;
         prev_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            armed_ff <= armed_in;
            pos_ff   <= pos_in;
            bits_ff  <= bits_in;
            prev_ff  <= prev_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_interval_ff <= req_ch.edge_interval;
      end
      if (s1_fire && emit) begin
         rsp_frame_ff <= bits_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.raw_frame      = rsp_frame_ff;
   assign rsp_ch.device_address = rsp_frame_ff[7:0];
   assign rsp_ch.command_code   = rsp_frame_ff[23:16];
   assign rsp_ch.frame_valid    = (rsp_frame_ff[23:16] ^ rsp_frame_ff[31:24]) == INV_MATCH;

   `NECIR_ASSERT_SAME(a_pos_range, clock, reset, 1'b1, pos_ff < FRAME_EDGES)
   `NECIR_ASSERT_SAME(a_disarmed_pos, clock, reset, !armed_ff, pos_ff == '0)
   `NECIR_ASSERT_NEXT(a_emit_disarms, clock, reset, s1_fire && emit, !armed_ff && rsp_valid_ff)
   `NECIR_ASSERT_NEXT(a_result_source, clock, reset,
                      !s1_valid_ff && !rsp_valid_ff, !rsp_valid_ff)

endmodule

@@ tb/nec_ir_frame_decoder_core_tb.sv @@
// ----------------------------------------------------------------------------
// NEC IR frame decoder core testbench
// Drives falling-edge intervals into the decoder and checks every decoded
// frame against a cycle-free model of the decoder kept in the testbench.
// Directed tests cover the window boundaries, sync restarts, repeated bits,
// overlapping and empty windows. They are followed by randomised frame
// traffic under changing window settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import necir_pkg::*;

   localparam int CYCLE_LIMIT       = 400_000;
   localparam int RANDOM_EDGES      = 1250;
   localparam int QUIET_EDGES       = 200;
   localparam int DRAIN_CYCLES      = 4;

   typedef struct {
      logic [BYTE_W-1:0]  address;
      logic [BYTE_W-1:0]  command;
      logic [FRAME_W-1:0] raw;
      logic               valid;
   } frame_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   necir_req_if req_ch ();
   necir_rsp_if rsp_ch ();

   // Window registers and decode state as the testbench expects them.
   logic [INTERVAL_W-1:0] sync_lo, sync_hi;
   logic [BYTE_W-1:0]     zero_lo, zero_hi, one_lo, one_hi;
   logic                  armed;
   logic [POS_W-1:0]      position;
   logic [FRAME_W-1:0]    bits_rx;
   logic                  last_bit;

   frame_type pending_frames[$];

   int errors;
   int edges_sent;
   int cycle_count;
   int req_gap_odds;
   int rsp_stall_odds;
   int noise_odds;
   int stall_left;

   nec_ir_frame_decoder_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   function automatic bit in_win(input int v, input int lo, input int hi);
      return v >= lo && v < hi;
   endfunction

   // Advances the expected decode state by one accepted edge.
   task automatic decode_edge(input logic [INTERVAL_W-1:0] t);
      logic      b;
      frame_type f;
      if (!armed) begin
         armed    = 1'b1;
         position = '0;
         return;
      end
      if (in_win(t, sync_lo, sync_hi))
         position = '0;
      if (position == 0 || position >= FRAME_EDGES) begin
         position = '0;
         bits_rx  = '0;
         last_bit = 1'b0;
      end else begin
         b = last_bit;
         if (in_win(t, zero_lo, zero_hi))
            b = 1'b0;
         else if (in_win(t, one_lo, one_hi))
            b = 1'b1;
         last_bit = b;
         bits_rx  = bits_rx | (FRAME_W'(b) << (position - 1));
      end
      position = position + 1'b1;
      if (position == FRAME_EDGES) begin
         position  = '0;
         armed     = 1'b0;
         f.address = bits_rx[7:0];
         f.command = bits_rx[23:16];
         f.raw     = bits_rx;
         f.valid   = (bits_rx[23:16] ^ bits_rx[31:24]) == INV_MATCH;
         pending_frames.push_back(f);
      end
   endtask

   function automatic void check_field(input string name, input logic [FRAME_W-1:0] want,
                                       input logic [FRAME_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      frame_type f;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_frames.size() == 0) begin
            $display("%0t ns: frame with none expected, expected nothing, actual %h",
                     $time, rsp_ch.raw_frame);
            errors++;
         end else begin
            f = pending_frames.pop_front();
            check_field("device_address", f.address, rsp_ch.device_address);
            check_field("command_code", f.command, rsp_ch.command_code);
            check_field("raw_frame", f.raw, rsp_ch.raw_frame);
            check_field("frame_valid", f.valid, rsp_ch.frame_valid);
         end
      end
   end

   // Result sink: ready drops for random bursts while stalling is enabled.
   always @(posedge clock) begin
      if (stall_left > 0)
         stall_left--;
      else if (rsp_stall_odds != 0 && $urandom_range(1, rsp_stall_odds) == 1)
         stall_left = $urandom_range(1, 10);
      rsp_ch.ready <= (stall_left == 0);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("nec_ir_frame_decoder_core regression: fail");
         $finish;
      end
   end

   // Sends one edge, possibly after an idle burst, and returns at its transfer.
   task automatic send_edge(input logic [INTERVAL_W-1:0] t);
      int gap;
      if (req_gap_odds != 0 && $urandom_range(1, req_gap_odds) == 1) begin
         req_ch.valid <= 1'b0;
         gap = $urandom_range(1, 10);
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.edge_interval <= t;
      do @(posedge clock); while (!req_ch.ready);
      decode_edge(t);
      edges_sent++;
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      case (idx)
         CSR_SYNC_MIN: sync_lo = data;
         CSR_SYNC_MAX: sync_hi = data;
         CSR_ZERO_MIN: zero_lo = data[BYTE_W-1:0];
         CSR_ZERO_MAX: zero_hi = data[BYTE_W-1:0];
         CSR_ONE_MIN:  one_lo  = data[BYTE_W-1:0];
         CSR_ONE_MAX:  one_hi  = data[BYTE_W-1:0];
         default: ;
      endcase
   endtask

   // The upper byte of the 8-bit registers carries random bits that must be ignored.
   task automatic set_windows(input logic [INTERVAL_W-1:0] s_lo, s_hi,
                              input logic [BYTE_W-1:0] z_lo, z_hi, o_lo, o_hi);
      csr_write(CSR_SYNC_MIN, s_lo);
      csr_write(CSR_SYNC_MAX, s_hi);
      csr_write(CSR_ZERO_MIN, {8'($urandom), z_lo});
      csr_write(CSR_ZERO_MAX, {8'($urandom), z_hi});
      csr_write(CSR_ONE_MIN, {8'($urandom), o_lo});
      csr_write(CSR_ONE_MAX, {8'($urandom), o_hi});
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [INTERVAL_W-1:0] pick_sync();
      if (sync_hi > sync_lo)
         return INTERVAL_W'($urandom_range(int'(sync_hi) - 1, int'(sync_lo)));
      return INTERVAL_W'($urandom);
   endfunction

   // An interval for one bit; noise is either fully random or a wide value
   // whose low byte may sit inside a bit window.
   function automatic logic [INTERVAL_W-1:0] pick_bit(input logic b);
      logic [BYTE_W-1:0] lo, hi;
      lo = b ? one_lo : zero_lo;
      hi = b ? one_hi : zero_hi;
      if ((noise_odds != 0 && $urandom_range(1, noise_odds) == 1) || hi <= lo) begin
         if ($urandom_range(0, 1))
            return INTERVAL_W'($urandom);
         return {8'($urandom_range(1, 255)), 8'($urandom)};
      end
      return INTERVAL_W'($urandom_range(int'(hi) - 1, int'(lo)));
   endfunction

   task automatic send_frame(input logic [FRAME_W-1:0] word, input int n_bits);
      if (!armed)
         send_edge(INTERVAL_W'($urandom));
      send_edge(pick_sync());
      for (int i = 0; i < n_bits; i++)
         send_edge(pick_bit(word[i]));
   endtask

   task automatic test_default_windows();
      send_frame(32'hFF0000FF, 32);
      send_frame(32'h00FFFF00, 32);
      send_frame(32'h12345678, 32);
   endtask

   // Window boundaries, a wide interval with an in-window low byte, repeated
   // bits and a sync restart in the middle of a frame.
   task automatic test_bit_edge_cases();
      logic [INTERVAL_W-1:0] seq[] = '{16'hFFFF, 16'd50, 16'd0, 16'd20, 16'h010A, 16'hFFFF,
                                       16'd15, 16'd8, 16'd25, 16'd18, 16'd24, 16'd149,
                                       16'd150, 16'd7, 16'd26};
      foreach (seq[i])
         send_edge(seq[i]);
      while (armed)
         send_edge(pick_bit(1'($urandom)));
   endtask

   // Where the zero and one windows overlap, the zero window wins.
   task automatic test_overlapping_windows();
      wait_idle();
      set_windows(16'd1000, 16'd2000, 8'd10, 8'd30, 8'd20, 8'd40);
      send_frame(32'hA55A0FF0, 32);
      send_frame(32'hFFFFFFFF, 32);
   endtask

   task automatic test_extreme_windows();
      wait_idle();
      set_windows(16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_frame(32'hFFFFFFFF, 32);
      wait_idle();
      set_windows(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      repeat (5)
         send_edge(pick_bit(1'($urandom)));
      // Every interval but the largest now restarts the frame.
      wait_idle();
      set_windows(16'd0, 16'hFFFF, 8'd0, 8'hFF, 8'd0, 8'hFF);
      repeat (3)
         send_edge(INTERVAL_W'($urandom));
      while (armed)
         send_edge(16'hFFFF);
   endtask

   task automatic random_windows();
      int z_lo, z_hi, o_lo, o_hi, s_lo, s_hi;
      if ($urandom_range(0, 4) == 0) begin
         set_windows(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom));
      end else begin
         z_lo = $urandom_range(0, 60);
         z_hi = z_lo + $urandom_range(1, 40);
         o_lo = z_hi + $urandom_range(0, 40);
         o_hi = o_lo + $urandom_range(1, 100);
         s_lo = $urandom_range(o_hi, 4000);
         s_hi = s_lo + $urandom_range(1, 20000);
         set_windows(16'(s_lo), 16'(s_hi), 8'(z_lo), 8'(z_hi), 8'(o_lo), 8'(o_hi));
      end
   endtask

   // Mostly complete frames with random content, some truncated frames and
   // some stray edges, under a new window setting every phase.
   task automatic test_random_traffic();
      int                 start_edges, phase_end;
      logic [FRAME_W-1:0] word;
      start_edges  = edges_sent;
      noise_odds   = 12;
      while (edges_sent - start_edges < RANDOM_EDGES) begin
         wait_idle();
         random_windows();
         if (edges_sent - start_edges > RANDOM_EDGES - QUIET_EDGES) begin
            req_gap_odds   = 0;
            rsp_stall_odds = 0;
         end else begin
            req_gap_odds   = 3 * $urandom_range(0, 3);
            rsp_stall_odds = 3 * $urandom_range(0, 3);
         end
         phase_end = edges_sent + 150;
         while (edges_sent < phase_end) begin
            word = $urandom;
            if ($urandom_range(0, 1))
               word[31:24] = ~word[23:16];
            case ($urandom_range(0, 9))
               0: send_edge(INTERVAL_W'($urandom));
               1: send_frame(word, $urandom_range(0, 31));
               default: send_frame(word, 32);
            endcase
         end
      end
   endtask

   initial begin
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_index            = CSR_SYNC_MIN;
      csr_wr_data          = '0;
      req_ch.valid         = 1'b0;
      req_ch.edge_interval = '0;
      rsp_ch.ready         = 1'b0;
      sync_lo  = SYNC_MIN_RST;
      sync_hi  = SYNC_MAX_RST;
      zero_lo  = ZERO_MIN_RST;
      zero_hi  = ZERO_MAX_RST;
      one_lo   = ONE_MIN_RST;
      one_hi   = ONE_MAX_RST;
      armed    = 1'b0;
      position = '0;
      bits_rx  = '0;
      last_bit = 1'b0;
      req_gap_odds   = 4;
      rsp_stall_odds = 4;
      noise_odds     = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_default_windows();
      test_bit_edge_cases();
      test_overlapping_windows();
      test_extreme_windows();
      test_random_traffic();
      wait_idle();

      if (errors == 0)
         $display("nec_ir_frame_decoder_core regression: pass");
      else
         $display("nec_ir_frame_decoder_core regression: fail");
      $finish;
   end

endmodule
